>>> rtl/core/tilt_kf_pkg.sv
// ---------------------------------------------------------------------------
// tilt_kf_pkg
// Shared types, constants and helpers of the tilt angle Kalman filter.
// ---------------------------------------------------------------------------
package tilt_kf_pkg;

  // Number of axis state sets and the index width into them
  localparam int NUM_AXES   = 2;
  localparam int AXIS_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  // Configuration register indexes
  localparam logic [1:0] REG_Q_ANGLE       = 2'd0;
  localparam logic [1:0] REG_Q_GYRO        = 2'd1;
  localparam logic [1:0] REG_R_ANGLE       = 2'd2;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd3;

  // Configuration reset values (unsigned Q1.30)
  localparam logic [30:0] Q_ANGLE_RST       = 31'd1073742;
  localparam logic [30:0] Q_GYRO_RST        = 31'd3221225;
  localparam logic [30:0] R_ANGLE_RST       = 31'd536870912;
  localparam logic [30:0] SAMPLE_PERIOD_RST = 31'd10737418;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  // Multiply-accumulate operation codes, in sequencing order
  localparam logic [3:0] OP_ANG   = 4'd0;  // angle += (rate - bias) * dt
  localparam logic [3:0] OP_P00   = 4'd1;  // P00 += d0 * dt
  localparam logic [3:0] OP_P01   = 4'd2;  // P01, P10 += -P11 * dt
  localparam logic [3:0] OP_P11   = 4'd3;  // P11 += q_gyro * dt
  localparam logic [3:0] OP_K1P00 = 4'd4;  // P10 -= K1 * P00
  localparam logic [3:0] OP_K1P01 = 4'd5;  // P11 -= K1 * P01
  localparam logic [3:0] OP_K0P01 = 4'd6;  // P01 -= K0 * P01
  localparam logic [3:0] OP_K0P00 = 4'd7;  // P00 -= K0 * P00
  localparam logic [3:0] OP_K0ERR = 4'd8;  // angle += K0 * err
  localparam logic [3:0] OP_K1ERR = 4'd9;  // bias += K1 * err

  // Divider geometry: 32 quotient bits, one per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       acc;
    logic       eval;
    logic       div_start;
    logic       div_sel;    // 0: K0 from P00, 1: K1 from P10
    logic       div_take;
    logic       wb;
    logic [3:0] op;
  } kf_cmd_t;

  typedef struct packed {
    logic e_pos;
    logic div_done;
    logic out_busy;
  } kf_status_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/tilt_kf_div.sv
// ---------------------------------------------------------------------------
// tilt_kf_div
// Gain divider: (p * 2^30) / den truncated toward zero, clamped to
// +/-(2^31 - 1). Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tilt_kf_div
  import tilt_kf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          sh_r, sh_nxt;
  logic [31:0]          q_r, q_nxt;
  logic [31:0]          den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [31:0] mag;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [31:0] q_mag;

  assign mag     = num[31] ? (32'd0 - num) : num;
  assign rem_sh  = {rem_r, sh_r[31]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // Iterate: shift in one numerator bit, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {2'b00, mag[31:2]};
      sh_nxt   = {mag[1:0], 30'd0};
      q_nxt    = '0;
      den_nxt  = den;
      neg_nxt  = num[31];
      ovf_nxt  = ({2'b00, mag[31:2]} >= den);
    end else if (busy_r) begin
      sh_nxt = {sh_r[30:0], 1'b0};
      if (!rem_sub[32]) begin
        rem_nxt = rem_sub[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
  end

  // Clamp the magnitude, then restore the sign
  assign q_mag = (ovf_r || q_r[31]) ? 32'h7FFFFFFF : q_r;
  assign quot  = neg_r ? (32'sd0 - $signed(q_mag)) : $signed(q_mag);
  assign done  = done_r;

endmodule

>>> rtl/core/tilt_kf_datapath.sv
// ---------------------------------------------------------------------------
// tilt_kf_datapath
// Axis state sets, configuration registers, the shared multiplier with its
// round-and-accumulate stage, the gain divider and the output register.
// ---------------------------------------------------------------------------
module tilt_kf_datapath
  import tilt_kf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  kf_cmd_t            cmd,
  output kf_status_t         status,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_axis,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_axis_out,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_bias_estimate
);

  // Configuration
  logic [30:0] q_angle_r, q_gyro_r, r_angle_r, dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_angle_r <= Q_ANGLE_RST;
      q_gyro_r  <= Q_GYRO_RST;
      r_angle_r <= R_ANGLE_RST;
      dt_r      <= SAMPLE_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_Q_ANGLE:       q_angle_r <= cfg_data;
        REG_Q_GYRO:        q_gyro_r  <= cfg_data;
        REG_R_ANGLE:       r_angle_r <= cfg_data;
        REG_SAMPLE_PERIOD: dt_r      <= cfg_data;
        default:           q_angle_r <= q_angle_r;
      endcase
    end
  end

  // Per-axis state
  logic signed [31:0] st_ang_r  [NUM_AXES];
  logic signed [31:0] st_bias_r [NUM_AXES];
  logic signed [31:0] st_p00_r  [NUM_AXES];
  logic signed [31:0] st_p01_r  [NUM_AXES];
  logic signed [31:0] st_p10_r  [NUM_AXES];
  logic signed [31:0] st_p11_r  [NUM_AXES];

  // Working registers for the current transaction
  logic [AXIS_IDX_W-1:0] sel_r;
  logic                  axis_r;
  logic signed [31:0]    meas_r, rate_r;
  logic signed [31:0]    ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0]    d0_r, k0_r, k1_r;
  logic signed [33:0]    e_r;
  logic signed [32:0]    err_r;
  logic signed [67:0]    prod_r;

  logic [AXIS_IDX_W-1:0] sel_in;
  assign sel_in = (NUM_AXES > 1) ? AXIS_IDX_W'(in_axis) : '0;

  // Multiplier operand select
  logic signed [33:0] mul_a, mul_b;
  logic signed [33:0] dt_s;
  assign dt_s = $signed({3'b000, dt_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ANG: begin
        mul_a = 34'(rate_r) - 34'(bias_r);
        mul_b = dt_s;
      end
      OP_P00: begin
        mul_a = 34'(d0_r);
        mul_b = dt_s;
      end
      OP_P01: begin
        mul_a = 34'sd0 - 34'(p11_r);
        mul_b = dt_s;
      end
      OP_P11: begin
        mul_a = $signed({3'b000, q_gyro_r});
        mul_b = dt_s;
      end
      OP_K1P00: begin
        mul_a = 34'(k1_r);
        mul_b = 34'(p00_r);
      end
      OP_K1P01: begin
        mul_a = 34'(k1_r);
        mul_b = 34'(p01_r);
      end
      OP_K0P01: begin
        mul_a = 34'(k0_r);
        mul_b = 34'(p01_r);
      end
      OP_K0P00: begin
        mul_a = 34'(k0_r);
        mul_b = 34'(p00_r);
      end
      OP_K0ERR: begin
        mul_a = 34'(k0_r);
        mul_b = 34'(err_r);
      end
      OP_K1ERR: begin
        mul_a = 34'(k1_r);
        mul_b = 34'(err_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round the product half up at bit 30, then add to or subtract from a base
  logic signed [67:0] prod_rnd;
  logic signed [39:0] rnd40;
  logic signed [39:0] base40;
  logic               sub;
  logic signed [31:0] sum_a, sum_b;
  logic signed [33:0] d0_wide;

  assign prod_rnd = prod_r + 68'sd536870912;
  assign rnd40    = 40'($signed(prod_rnd[67:30]));

  always_comb begin
    base40 = 40'(ang_r);
    sub    = 1'b0;
    case (cmd.op)
      OP_ANG:   base40 = 40'(ang_r);
      OP_P00:   base40 = 40'(p00_r);
      OP_P01:   base40 = 40'(p01_r);
      OP_P11:   base40 = 40'(p11_r);
      OP_K1P00: begin
        base40 = 40'(p10_r);
        sub    = 1'b1;
      end
      OP_K1P01: begin
        base40 = 40'(p11_r);
        sub    = 1'b1;
      end
      OP_K0P01: begin
        base40 = 40'(p01_r);
        sub    = 1'b1;
      end
      OP_K0P00: begin
        base40 = 40'(p00_r);
        sub    = 1'b1;
      end
      OP_K0ERR: base40 = 40'(ang_r);
      OP_K1ERR: base40 = 40'(bias_r);
      default:  base40 = 40'(ang_r);
    endcase
  end

  assign sum_a   = sat32(sub ? (base40 - rnd40) : (base40 + rnd40));
  assign sum_b   = sat32(40'(p10_r) + rnd40);
  assign d0_wide = 34'($signed({1'b0, q_angle_r})) - 34'(p01_r) - 34'(p10_r);

  // Gain divider
  logic               div_done;
  logic signed [31:0] div_quot;

  tilt_kf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? p10_r : p00_r),
    .den   (e_r[31:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Working register updates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel_r  <= sel_in;
      axis_r <= in_axis;
      meas_r <= in_accel_angle;
      rate_r <= in_gyro_rate;
      ang_r  <= st_ang_r[sel_in];
      bias_r <= st_bias_r[sel_in];
      p00_r  <= st_p00_r[sel_in];
      p01_r  <= st_p01_r[sel_in];
      p10_r  <= st_p10_r[sel_in];
      p11_r  <= st_p11_r[sel_in];
    end
    if (cmd.mul) begin
      prod_r <= mul_a * mul_b;
      if (cmd.op == OP_ANG) begin
        d0_r <= sat32(40'(d0_wide));
      end
    end
    if (cmd.acc) begin
      case (cmd.op)
        OP_ANG, OP_K0ERR:   ang_r  <= sum_a;
        OP_K1ERR:           bias_r <= sum_a;
        OP_P00, OP_K0P00:   p00_r  <= sum_a;
        OP_K0P01:           p01_r  <= sum_a;
        OP_P01: begin
          p01_r <= sum_a;
          p10_r <= sum_b;
        end
        OP_K1P00:           p10_r  <= sum_a;
        OP_P11, OP_K1P01:   p11_r  <= sum_a;
        default:            ang_r  <= ang_r;
      endcase
    end
    if (cmd.eval) begin
      e_r   <= $signed({3'b000, r_angle_r}) + 34'(p00_r);
      err_r <= 33'(meas_r) - 33'(ang_r);
    end
    if (cmd.div_take) begin
      if (cmd.div_sel) begin
        k1_r <= div_quot;
      end else begin
        k0_r <= div_quot;
      end
    end
  end

  // Write back the state set of this axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        st_ang_r[i]  <= '0;
        st_bias_r[i] <= '0;
        st_p00_r[i]  <= ONE_Q30;
        st_p01_r[i]  <= '0;
        st_p10_r[i]  <= '0;
        st_p11_r[i]  <= ONE_Q30;
      end
    end else if (cmd.wb) begin
      st_ang_r[sel_r]  <= ang_r;
      st_bias_r[sel_r] <= bias_r;
      st_p00_r[sel_r]  <= p00_r;
      st_p01_r[sel_r]  <= p01_r;
      st_p10_r[sel_r]  <= p10_r;
      st_p11_r[sel_r]  <= p11_r;
    end
  end

  // Output register
  logic               out_valid_r;
  logic               out_axis_r;
  logic signed [31:0] out_ang_r, out_bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.wb) begin
      out_axis_r <= axis_r;
      out_ang_r  <= ang_r;
      out_bias_r <= bias_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_axis_out       = out_axis_r;
  assign out_angle_estimate = out_ang_r;
  assign out_bias_estimate  = out_bias_r;

  assign status.e_pos    = (e_r > 34'sd0);
  assign status.div_done = div_done;
  assign status.out_busy = out_valid_r && out_stall;

endmodule

>>> rtl/core/tilt_kf_ctrl.sv
// ---------------------------------------------------------------------------
// tilt_kf_ctrl
// Sequencer: steps the datapath through prediction, gain division and
// correction for one transaction at a time.
// ---------------------------------------------------------------------------
module tilt_kf_ctrl
  import tilt_kf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  kf_status_t status,
  output kf_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_ACC      = 3'd2;
  localparam logic [2:0] S_EVAL     = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_DIV_WAIT = 3'd6;
  localparam logic [2:0] S_WB       = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic       dsel_r, dsel_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dsel_nxt      = dsel_r;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.div_sel   = dsel_r;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_ANG;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (op_r == OP_P11) begin
          state_nxt = S_EVAL;
        end else if (op_r == OP_K1ERR) begin
          state_nxt = S_WB;
        end else begin
          op_nxt    = op_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        dsel_nxt  = 1'b0;
        state_nxt = status.e_pos ? S_DIV : S_WB;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          if (!dsel_r) begin
            dsel_nxt  = 1'b1;
            state_nxt = S_DIV;
          end else begin
            op_nxt    = OP_K1P00;
            state_nxt = S_MUL;
          end
        end
      end
      S_WB: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.wb    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_ANG;
      dsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

endmodule

>>> rtl/core/tilt_angle_kalman_filter.sv
// ---------------------------------------------------------------------------
// tilt_angle_kalman_filter
// Two-state (angle, gyro bias) Kalman filter with one state set per axis.
// ---------------------------------------------------------------------------
// One transaction is processed at a time, and a new one is taken only after
// the result of the last is written back: four multiply-accumulate steps for
// the prediction, each a multiply and then an accumulate, then forming the
// innovation and checking its variance, two gain divisions on the shared
// bit-per-cycle divider, six multiply-accumulate steps for the correction
// and a write-back; when the innovation variance is not positive the
// divisions and correction are skipped and the sequencer goes from the
// check straight to the write-back.
// The shared multiplier and the divider bound the throughput. A finished
// result waits in the output register while the next transaction is taken.
// Configuration writes are always taken (cfg_ready is tied high).
module tilt_angle_kalman_filter
  import tilt_kf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_axis,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_axis_out,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_bias_estimate
);

  kf_cmd_t    cmd;
  kf_status_t status;

  assign cfg_ready = 1'b1;

  tilt_kf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tilt_kf_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_axis            (in_axis),
    .in_accel_angle     (in_accel_angle),
    .in_gyro_rate       (in_gyro_rate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_axis_out       (out_axis_out),
    .out_angle_estimate (out_angle_estimate),
    .out_bias_estimate  (out_bias_estimate)
  );

endmodule

>>> dv/tb_tilt_angle_kalman_filter.sv
// ---------------------------------------------------------------------------
// tb_tilt_angle_kalman_filter
// Self-checking bench: a scoreboard predicts the two-state filter per axis in
// 64-bit fixed point and compares every result transaction, while the tasks
// below drive samples, configuration and random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tilt_angle_kalman_filter;
  import tilt_kf_pkg::*;

  typedef struct {
    logic              axis;
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  // Predict filter outputs and check results in order
  class estimate_scoreboard;
    logic [30:0] q_angle, q_gyro, r_angle, dt;
    longint ang [NUM_AXES];
    longint bias [NUM_AXES];
    longint p00 [NUM_AXES];
    longint p01 [NUM_AXES];
    longint p10 [NUM_AXES];
    longint p11 [NUM_AXES];
    estimate_t pending[$];
    int errors;

    function new();
      errors = 0;
      q_angle = Q_ANGLE_RST;
      q_gyro = Q_GYRO_RST;
      r_angle = R_ANGLE_RST;
      dt = SAMPLE_PERIOD_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        ang[i] = 0; bias[i] = 0; p01[i] = 0; p10[i] = 0;
        p00[i] = 64'sd1073741824; p11[i] = 64'sd1073741824;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] v);
      case (idx)
        REG_Q_ANGLE: q_angle = v;
        REG_Q_GYRO: q_gyro = v;
        REG_R_ANGLE: r_angle = v;
        REG_SAMPLE_PERIOD: dt = v;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint c32(longint v);
      return clamp(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function longint round30(longint v);
      return (v + 64'sd536870912) >>> 30;
    endfunction

    function longint gain_of(longint num, longint den);
      return clamp((num * 64'sd1073741824) / den, -64'sd2147483647, 64'sd2147483647);
    endfunction

    // Note an accepted sample and queue its expected estimate
    function void note_sample(logic ax, logic signed [31:0] meas, logic signed [31:0] rate);
      int s;
      longint d, a, b, n00, n01, n10, n11, e, err, k0, k1, t0, t1, ldt;
      estimate_t x;
      s = ax % NUM_AXES;
      ldt = longint'(dt);
      a = c32(ang[s] + round30((longint'(rate) - bias[s]) * ldt));
      b = bias[s];
      d = c32(longint'(q_angle) - p01[s] - p10[s]);
      n00 = c32(p00[s] + round30(d * ldt));
      n01 = c32(p01[s] + round30(-p11[s] * ldt));
      n10 = c32(p10[s] + round30(-p11[s] * ldt));
      n11 = c32(p11[s] + round30(longint'(q_gyro) * ldt));
      e = longint'(r_angle) + n00;
      if (e > 0) begin
        err = longint'(meas) - a;
        k0 = gain_of(n00, e);
        k1 = gain_of(n10, e);
        t0 = n00; t1 = n01;
        n00 = c32(n00 - round30(k0 * t0));
        n01 = c32(n01 - round30(k0 * t1));
        n10 = c32(n10 - round30(k1 * t0));
        n11 = c32(n11 - round30(k1 * t1));
        a = c32(a + round30(k0 * err));
        b = c32(b + round30(k1 * err));
      end
      ang[s] = a; bias[s] = b;
      p00[s] = n00; p01[s] = n01; p10[s] = n10; p11[s] = n11;
      x.axis = ax; x.angle = a[31:0]; x.bias = b[31:0];
      pending.push_back(x);
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic ax, logic signed [31:0] a, logic signed [31:0] b);
      estimate_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result axis=%0d angle=%0d bias=%0d", $time, ax, a, b);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (ax !== x.axis) begin
        $display("%0t: axis exp %0d got %0d", $time, x.axis, ax);
        errors++;
      end
      if (a !== x.angle) begin
        $display("%0t: angle exp %0d got %0d", $time, x.angle, a);
        errors++;
      end
      if (b !== x.bias) begin
        $display("%0t: bias exp %0d got %0d", $time, x.bias, b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_axis = 1'b0;
  logic signed [31:0] in_accel_angle = '0;
  logic signed [31:0] in_gyro_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_axis_out;
  logic signed [31:0] out_angle_estimate;
  logic signed [31:0] out_bias_estimate;

  estimate_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_off = 0;
  longint cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tilt_angle_kalman_filter dut (.*);

  // Sample both channels at the edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall)
      sb.note_sample(in_axis, in_accel_angle, in_gyro_rate);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_axis_out, out_angle_estimate, out_bias_estimate);
  end

  // Receiver stall: random, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 19);
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    if (cycle_count > 3000000) begin
      $display("tb_tilt_angle_kalman_filter: errors");
      $finish;
    end
  end

  // Offer one sample; valid stays high into the next call unless it idles
  task automatic send_sample(logic ax, logic signed [31:0] meas, logic signed [31:0] rate);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_axis <= ax;
    in_accel_angle <= meas;
    in_gyro_rate <= rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic config_all(logic [30:0] qa, logic [30:0] qg, logic [30:0] r,
                            logic [30:0] d);
    write_cfg(REG_Q_ANGLE, qa);
    write_cfg(REG_Q_GYRO, qg);
    write_cfg(REG_R_ANGLE, r);
    write_cfg(REG_SAMPLE_PERIOD, d);
    cfg_valid <= 1'b0;
  endtask

  // Plausible IMU sample: small angle and slow rate, else full range
  task automatic random_sample();
    logic signed [31:0] m, g;
    if ($urandom_range(9) < 8) begin
      m = $signed($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536;
      g = $signed($urandom_range(0, 2 * 300 * 65536)) - 300 * 65536;
    end else begin
      m = $urandom;
      g = $urandom;
    end
    send_sample(1'($urandom_range(1)), m, g);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and small values on both axes with reset settings
    send_sample(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_sample(1'b1, 32'sh80000000, 32'sh80000000);
    send_sample(1'b0, 32'sh80000000, 32'sh7FFFFFFF);
    send_sample(1'b1, 32'sh7FFFFFFF, 32'sh80000000);
    send_sample(1'b0, 0, 0);
    send_sample(1'b1, -1, -1);
    send_sample(1'b0, 32'sh00010000, 32'sh00050000);
    drain();

    // Extreme settings: largest process noise and dt, smallest r_angle, drive covariance to saturation
    config_all(31'h7FFFFFFF, 31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF);
    for (int i = 0; i < 8; i++) send_sample(i[0], 32'sh7FFFFFFF - i, 32'sh80000000 + i);
    drain();
    // Minimum settings: zero dt and noise, tiny r_angle
    config_all(31'd0, 31'd0, 31'd1, 31'd0);
    for (int i = 0; i < 6; i++) send_sample(i[0], $urandom, $urandom);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: config_all(Q_ANGLE_RST, Q_GYRO_RST, R_ANGLE_RST, SAMPLE_PERIOD_RST);
        1: config_all(31'($urandom), 31'($urandom), 31'h7FFFFFFF,
                      31'($urandom_range(0, 31'h3FFFFFF)));
        2: config_all(31'd0, 31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF);
        default: config_all(31'($urandom), 31'($urandom),
                            31'($urandom_range(1, 31'h7FFFFFFF)), 31'($urandom));
      endcase
      calm = (ph == 1);
      if (ph == 3) hold_off <= 400;
      for (int i = 0; i < 235; i++) random_sample();
      calm = 1'b0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_tilt_angle_kalman_filter: clean");
    end else begin
      $display("tb_tilt_angle_kalman_filter: errors");
    end
    $finish;
  end

endmodule
